[hw/rtl/modbus_time_register_responder_top_defines.svh]
// assertion macros for the responder
`ifndef MODBUS_TIME_REGISTER_RESPONDER_TOP_DEFINES_SVH
`define MODBUS_TIME_REGISTER_RESPONDER_TOP_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define MTR_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%s failed", "lbl");
// next-cycle implication
`define MTR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%s failed", "lbl");
`endif

[hw/rtl/mtr_pkg.sv]
// ----------------------------------------------------------------------------
// mtr_pkg
// shared types, constants and helpers of the modbus time register responder
// ----------------------------------------------------------------------------
package mtr_pkg;
   localparam int FRAME_BYTES = 8;
   localparam int RESP_MAX    = 11;
   localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
   localparam logic [7:0]  FUNC_EXCEPTION  = 8'h84;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;
   localparam logic [15:0] REG_HOURS = 16'd4001;
   localparam logic [15:0] REG_MINS  = 16'd4002;
   localparam logic [15:0] REG_SECS  = 16'd4003;
   localparam logic [7:0]  SLAVE_ADDRESS_RESET    = 8'd1;
   localparam logic [11:0] TICKS_PER_SECOND_RESET = 12'd1600;
   localparam logic [11:0] GAP_LIMIT_RESET        = 12'd900;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_SLAVE_ADDRESS    = 2'd0,
      CSR_TICKS_PER_SECOND = 2'd1,
      CSR_GAP_LIMIT        = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      EXC_NONE     = 2'd0,
      EXC_FUNCTION = 2'd1,
      EXC_ADDRESS  = 2'd2,
      EXC_COUNT    = 2'd3
   } exc_code_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CHECK,
      BK_BUILD,
      BK_CRC,
      BK_SEND
   } back_state_type;

   // captured frame with clock snapshot, passed front to back
   typedef struct packed {
      logic [FRAME_BYTES-1:0][7:0] bytes;
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } frame_type;

   // one byte of crc update, eight shift steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction
endpackage

[hw/rtl/mtr_stream_if.sv]
// ----------------------------------------------------------------------------
// mtr_req_if / mtr_rsp_if
// valid/ready channels of the responder
// ----------------------------------------------------------------------------
interface mtr_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] rx_byte;
   modport source (output valid, output opcode, output rx_byte, input ready);
   modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface mtr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       last;
   modport source (output valid, output tx_byte, output last, input ready);
   modport sink   (input valid, input tx_byte, input last, output ready);
endinterface

[hw/rtl/mtr_front.sv]
// ----------------------------------------------------------------------------
// mtr_front
// takes bytes and ticks, runs gap counter and clock, assembles frames
// ----------------------------------------------------------------------------
module mtr_front
   import mtr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mtr_req_if.sink     req,
   input  logic [11:0] ticks_per_second,
   input  logic [11:0] gap_limit,
   input  logic        queue_full,
   output logic        frame_push,
   output frame_type   frame_data
);
   logic [FRAME_BYTES-1:0][7:0] store_ff, store_in;
   logic [3:0]  index_ff, index_in;
   logic [11:0] idle_ff, idle_in;
   logic [11:0] div_ff, div_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic        accept;
   logic [2:0]  slot;
   logic [11:0] period;

   // a full queue blocks every request, bytes and ticks alike
   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign period    = (ticks_per_second == 12'd0) ? 12'd1 : ticks_per_second;

   always_comb begin
      store_in   = store_ff;
      index_in   = index_ff;
      idle_in    = idle_ff;
      div_in     = div_ff;
      sec_in     = sec_ff;
      min_in     = min_ff;
      hour_in    = hour_ff;
      frame_push = 1'b0;
      slot       = 3'd0;
      frame_data.bytes   = store_ff;
      frame_data.hours   = hour_ff;
      frame_data.minutes = min_ff;
      frame_data.seconds = sec_ff;
      if (accept && req.opcode == OP_TICK) begin
         if (idle_ff != 12'hFFF) idle_in = idle_ff + 12'd1;
         if ({1'b0, div_ff} + 13'd1 >= {1'b0, period}) begin
            div_in = 12'd0;
            sec_in = sec_ff + 6'd1;
            if (sec_in >= 6'd60) begin
               sec_in = 6'd0;
               min_in = min_ff + 6'd1;
            end
            if (min_in >= 6'd60) begin
               min_in  = 6'd0;
               hour_in = hour_ff + 5'd1;
            end
            if (hour_in >= 5'd24) hour_in = 5'd0;
         end else begin
            div_in = div_ff + 12'd1;
         end
      end else if (accept) begin
         slot = (idle_ff > gap_limit) ? 3'd0 : index_ff[2:0];
         store_in[slot] = req.rx_byte;
         idle_in = 12'd0;
         if (slot == 3'(FRAME_BYTES - 1)) begin
            index_in   = 4'd0;
            frame_push = 1'b1;
            frame_data.bytes = store_in;
         end else begin
            index_in = {1'b0, slot} + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
      if (reset) begin
         index_ff <= '0;
         idle_ff  <= '0;
         div_ff   <= '0;
         sec_ff   <= '0;
         min_ff   <= '0;
         hour_ff  <= '0;
      end else begin
         index_ff <= index_in;
         idle_ff  <= idle_in;
         div_ff   <= div_in;
         sec_ff   <= sec_in;
         min_ff   <= min_in;
         hour_ff  <= hour_in;
      end
   end
endmodule

[hw/rtl/mtr_queue.sv]
// ----------------------------------------------------------------------------
// mtr_queue
// two-entry frame queue between front and back
// ----------------------------------------------------------------------------
module mtr_queue
   import mtr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_data,
   input  logic      pop,
   output logic      full,
   output logic      not_empty,
   output frame_type head
);
   frame_type  mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_data;
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop)  rptr_ff <= !rptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

[hw/rtl/mtr_back.sv]
// ----------------------------------------------------------------------------
// mtr_back
// checks a queued frame's crc, drops it on a mismatch, else builds the response and sends it
// ----------------------------------------------------------------------------
module mtr_back
   import mtr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       frame_valid,
   input  frame_type  frame,
   output logic       frame_pop,
   input  logic [7:0] slave_address,
   mtr_rsp_if.source  rsp
);
   back_state_type state_ff, state_in;
   logic [15:0] crc_ff, crc_in;
   logic [3:0]  pos_ff, pos_in;
   logic [3:0]  len_ff, len_in;
   logic [RESP_MAX-1:0][7:0] resp_ff, resp_in;
   logic [15:0] start, count;
   logic [7:0]  crc_src;
   exc_code_type code;
   logic [1:0]  cnt2;

   assign start = {frame.bytes[2], frame.bytes[3]};
   assign count = {frame.bytes[4], frame.bytes[5]};
   assign cnt2  = count[1:0];

   always_comb begin
      if (frame.bytes[1] != FUNC_READ_INPUT) code = EXC_FUNCTION;
      else if (start < REG_HOURS || start > REG_SECS) code = EXC_ADDRESS;
      else if (count == 16'd0 || count > 16'd3 || start + count > 16'd4004) code = EXC_COUNT;
      else code = EXC_NONE;
   end

   function automatic logic [7:0] reg_val(input logic [15:0] r, input frame_type f);
      if (r == REG_HOURS) return {3'd0, f.hours};
      if (r == REG_MINS)  return {2'd0, f.minutes};
      return {2'd0, f.seconds};
   endfunction

   always_comb begin
      state_in  = state_ff;
      crc_in    = crc_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      resp_in   = resp_ff;
      frame_pop = 1'b0;
      crc_src   = (state_ff == BK_CHECK) ? frame.bytes[pos_ff[2:0]] : resp_ff[pos_ff];
      rsp.valid   = (state_ff == BK_SEND);
      rsp.tx_byte = resp_ff[pos_ff];
      rsp.last    = (pos_ff == len_ff - 4'd1);
      unique case (state_ff)
         BK_IDLE: begin
            if (frame_valid) begin
               state_in = BK_CHECK;
               crc_in   = CRC_INIT;
               pos_in   = 4'd0;
            end
         end
         BK_CHECK: begin
            // one frame byte of crc per cycle
            crc_in = crc_byte(crc_ff, crc_src);
            pos_in = pos_ff + 4'd1;
            if (pos_ff == 4'd5) state_in = BK_BUILD;
         end
         BK_BUILD: begin
            if (frame.bytes[6] != crc_ff[7:0] || frame.bytes[7] != crc_ff[15:8]) begin
               frame_pop = 1'b1;
               state_in  = BK_IDLE;
            end else begin
               resp_in[0] = slave_address;
               if (code != EXC_NONE) begin
                  resp_in[1] = FUNC_EXCEPTION;
                  resp_in[2] = {6'd0, code};
                  len_in     = 4'd5;
               end else begin
                  resp_in[1] = FUNC_READ_INPUT;
                  resp_in[2] = {5'd0, cnt2, 1'b0};
                  resp_in[3] = 8'h00;
                  resp_in[4] = reg_val(start, frame);
                  resp_in[5] = 8'h00;
                  resp_in[6] = reg_val(start + 16'd1, frame);
                  resp_in[7] = 8'h00;
                  resp_in[8] = reg_val(start + 16'd2, frame);
                  len_in     = 4'd5 + {1'b0, cnt2, 1'b0};
               end
               crc_in    = CRC_INIT;
               pos_in    = 4'd0;
               frame_pop = 1'b1;
               state_in  = BK_CRC;
            end
         end
         BK_CRC: begin
            crc_in = crc_byte(crc_ff, crc_src);
            pos_in = pos_ff + 4'd1;
            if (pos_ff == len_ff - 4'd3) begin
               resp_in[len_ff - 4'd2] = crc_in[7:0];
               resp_in[len_ff - 4'd1] = crc_in[15:8];
               pos_in   = 4'd0;
               state_in = BK_SEND;
            end
         end
         BK_SEND: begin
            if (rsp.ready) begin
               pos_in = pos_ff + 4'd1;
               if (rsp.last) state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      crc_ff  <= crc_in;
      len_ff  <= len_in;
      resp_ff <= resp_in;
      if (reset) begin
         state_ff <= BK_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end
endmodule

[hw/rtl/modbus_time_register_responder_top.sv]
// Modbus RTU read-input-registers responder with an h:m:s clock. Ticks and
// bytes are taken one a cycle by the front end while its two-frame queue has
// room; a completed 8-byte frame gets a crc check of its first six bytes, a
// build step and a response crc in the back end, then one response byte is
// sent per cycle while rsp.ready is high; the crc unit sets the frame latency.
// Registers: 0 slave_address, 1 ticks_per_second, 2 gap_limit at 4*i.
module modbus_time_register_responder_top
   import mtr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mtr_req_if.sink     req,
   mtr_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [7:0]  addr_ff;
   logic [11:0] tps_ff, gap_ff;
   logic        push, pop, full, not_empty;
   frame_type   push_data, head;
   csr_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      unique case (csr_idx)
         CSR_SLAVE_ADDRESS:    csr_prdata = {24'd0, addr_ff};
         CSR_TICKS_PER_SECOND: csr_prdata = {20'd0, tps_ff};
         CSR_GAP_LIMIT:        csr_prdata = {20'd0, gap_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= SLAVE_ADDRESS_RESET;
         tps_ff  <= TICKS_PER_SECOND_RESET;
         gap_ff  <= GAP_LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (csr_idx)
            CSR_SLAVE_ADDRESS:    addr_ff <= csr_pwdata[7:0];
            CSR_TICKS_PER_SECOND: tps_ff  <= csr_pwdata[11:0];
            CSR_GAP_LIMIT:        gap_ff  <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   mtr_front u_front (
      .clock, .reset, .req,
      .ticks_per_second(tps_ff), .gap_limit(gap_ff),
      .queue_full(full), .frame_push(push), .frame_data(push_data)
   );

   mtr_queue u_queue (
      .clock, .reset, .push, .push_data, .pop, .full, .not_empty, .head
   );

   mtr_back u_back (
      .clock, .reset, .frame_valid(not_empty), .frame(head), .frame_pop(pop),
      .slave_address(addr_ff), .rsp
   );
endmodule

[hw/rtl/mtr_checker.sv]
// ----------------------------------------------------------------------------
// mtr_checker
// port-level checks of the responder
// ----------------------------------------------------------------------------
`include "modbus_time_register_responder_top_defines.svh"
module mtr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_last,
   input logic       csr_pready
);
   `MTR_ASSERT_IMPL(a_pready_high, 1'b1, csr_pready)
   `MTR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_tx_byte))
   `MTR_ASSERT_NEXT(a_last_ends, rsp_valid && rsp_ready && rsp_last, !rsp_valid)
endmodule

bind modbus_time_register_responder_top mtr_checker u_mtr_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_tx_byte(rsp.tx_byte), .rsp_last(rsp.last),
   .csr_pready(csr_pready)
);
